FILE: sv/sha1md_pkg.sv
`default_nettype none
package sha1md_pkg;

	localparam int unsigned FILL_W  = 6;
	localparam int unsigned TOTAL_W = 61;
	localparam int unsigned ROUND_W = 7;
	localparam int unsigned WIDX_W  = 3;

	localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
	localparam logic [FILL_W-1:0]  LEN_START  = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
	localparam logic [WIDX_W-1:0]  LAST_WORD  = 3'd4;
	localparam logic [7:0]         MARK_BYTE  = 8'h80;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN
	} pad_sel_t;

	typedef enum logic [1:0] {
		STG_CH,
		STG_PAR1,
		STG_MAJ,
		STG_PAR2
	} stage_t;

	typedef struct packed {
		logic              absorb;
		logic              pad_shift;
		pad_sel_t          pad_sel;
		logic              rnd_load;
		logic              rnd_step;
		stage_t            stage;
		logic              chain_add;
		logic              chain_init;
		logic [WIDX_W-1:0] word_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
	} dp_stat_t;

	function automatic logic [31:0] round_const(stage_t s);
		logic [31:0] k;
		case (s)
			STG_CH:   k = 32'h5A827999;
			STG_PAR1: k = 32'h6ED9EBA1;
			STG_MAJ:  k = 32'h8F1BBCDC;
			STG_PAR2: k = 32'hCA62C1D6;
			default:  k = 32'h5A827999;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

FILE: sv/sha1md_if.sv
`default_nettype none
interface sha1md_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte, output end_of_message,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input end_of_message,
		output ready);
endinterface

interface sha1md_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface
`default_nettype wire

FILE: sv/sha1md_ctrl.sv
`default_nettype none
module sha1md_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 msg_valid,
	input  wire logic                 msg_has_byte,
	input  wire logic                 msg_end,
	output logic                      msg_ready,
	output logic                      dig_valid,
	input  wire logic                 dig_ready,
	input  wire sha1md_pkg::dp_stat_t stat,
	output sha1md_pkg::dp_cmd_t       cmd
);

	sha1md_pkg::state_t                    state_q, state_d;
	logic [sha1md_pkg::ROUND_W-1:0]        round_q;
	logic [sha1md_pkg::WIDX_W-1:0]         word_q;
	logic                                  fin_q;
	logic                                  mark_q;
	logic                                  lenok_q;
	logic                                  fire;
	logic                                  full_next;
	logic                                  done_blk;

	// ready is high exactly in idle, so take the item on state alone
	assign fire      = msg_valid && (state_q == sha1md_pkg::ST_IDLE);
	// the shift in this cycle fills the last byte slot
	assign full_next = (stat.fill == sha1md_pkg::FILL_LAST);
	assign done_blk  = mark_q && lenok_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha1md_pkg::ST_IDLE: begin
				if (fire && msg_has_byte && full_next) begin
					state_d = sha1md_pkg::ST_ROUND;
				end else if (fire && msg_end) begin
					state_d = sha1md_pkg::ST_PAD;
				end
			end
			sha1md_pkg::ST_ROUND: begin
				if (round_q == sha1md_pkg::ROUND_LAST) begin
					state_d = sha1md_pkg::ST_ADD;
				end
			end
			sha1md_pkg::ST_ADD: begin
				if (!fin_q) begin
					state_d = sha1md_pkg::ST_IDLE;
				end else if (done_blk) begin
					state_d = sha1md_pkg::ST_OUT;
				end else begin
					state_d = sha1md_pkg::ST_PAD;
				end
			end
			sha1md_pkg::ST_PAD: begin
				if (full_next) begin
					state_d = sha1md_pkg::ST_ROUND;
				end
			end
			sha1md_pkg::ST_OUT: begin
				if (dig_ready && word_q == sha1md_pkg::LAST_WORD) begin
					state_d = sha1md_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1md_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		msg_ready      = 1'b0;
		dig_valid      = 1'b0;
		cmd            = '0;
		cmd.pad_sel    = sha1md_pkg::PAD_ZERO;
		cmd.stage      = sha1md_pkg::STG_CH;
		cmd.word_sel   = word_q;
		case (state_q)
			sha1md_pkg::ST_IDLE: begin
				msg_ready    = 1'b1;
				cmd.absorb   = fire && msg_has_byte;
				cmd.rnd_load = fire && msg_has_byte && full_next;
			end
			sha1md_pkg::ST_ROUND: begin
				cmd.rnd_step = 1'b1;
				if (round_q < 7'd20) begin
					cmd.stage = sha1md_pkg::STG_CH;
				end else if (round_q < 7'd40) begin
					cmd.stage = sha1md_pkg::STG_PAR1;
				end else if (round_q < 7'd60) begin
					cmd.stage = sha1md_pkg::STG_MAJ;
				end else begin
					cmd.stage = sha1md_pkg::STG_PAR2;
				end
			end
			sha1md_pkg::ST_ADD: begin
				cmd.chain_add = 1'b1;
			end
			sha1md_pkg::ST_PAD: begin
				cmd.pad_shift = 1'b1;
				cmd.rnd_load  = full_next;
				if (!mark_q) begin
					cmd.pad_sel = sha1md_pkg::PAD_MARK;
				end else if (lenok_q && stat.fill >= sha1md_pkg::LEN_START) begin
					cmd.pad_sel = sha1md_pkg::PAD_LEN;
				end else begin
					cmd.pad_sel = sha1md_pkg::PAD_ZERO;
				end
			end
			sha1md_pkg::ST_OUT: begin
				dig_valid      = 1'b1;
				cmd.chain_init = dig_ready && word_q == sha1md_pkg::LAST_WORD;
			end
			default: begin
				msg_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1md_pkg::ST_IDLE;
			round_q <= '0;
			word_q  <= '0;
			fin_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rnd_load) begin
				round_q <= '0;
			end else if (cmd.rnd_step) begin
				round_q <= round_q + 7'd1;
			end
			if (fire) begin
				fin_q  <= msg_end;
				mark_q <= 1'b0;
			end
			// the mark decides whether the length fits in this block
			if (cmd.pad_shift && !mark_q) begin
				mark_q  <= 1'b1;
				lenok_q <= (stat.fill < sha1md_pkg::LEN_START);
			end
			if (cmd.chain_add && fin_q && mark_q && !lenok_q) begin
				lenok_q <= 1'b1;
			end
			if (dig_valid && dig_ready) begin
				if (word_q == sha1md_pkg::LAST_WORD) begin
					word_q <= '0;
				end else begin
					word_q <= word_q + 3'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/sha1md_dp.sv
`default_nettype none
module sha1md_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           data_byte,
	input  wire sha1md_pkg::dp_cmd_t  cmd,
	output sha1md_pkg::dp_stat_t      stat,
	output logic [31:0]               digest_word,
	output logic [2:0]                word_index,
	output logic                      last_word
);

	logic [4:0][31:0]                  h_q;
	logic [511:0]                      blk_q;
	logic [sha1md_pkg::FILL_W-1:0]     fill_q;
	logic [sha1md_pkg::TOTAL_W-1:0]    total_q;
	logic [31:0]                       a_q, b_q, c_q, d_q, e_q;

	logic [63:0]  bit_len;
	logic [5:0]   len_lsb;
	logic [7:0]   pad_byte;
	logic [7:0]   shift_byte;
	logic         shift_en;
	logic [31:0]  s0, s2, s8, s13, sx, w_new;
	logic [31:0]  f_val;
	logic [31:0]  t_val;

	assign stat.fill = fill_q;

	// length bytes go out most significant first
	assign bit_len = {total_q, 3'b000};
	assign len_lsb = {~fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.pad_sel)
			sha1md_pkg::PAD_MARK: pad_byte = sha1md_pkg::MARK_BYTE;
			sha1md_pkg::PAD_LEN:  pad_byte = bit_len[len_lsb +: 8];
			sha1md_pkg::PAD_ZERO: pad_byte = 8'h00;
			default:              pad_byte = 8'h00;
		endcase
	end

	assign shift_en   = cmd.absorb || cmd.pad_shift;
	assign shift_byte = cmd.absorb ? data_byte : pad_byte;

	// the block register doubles as the 16-word schedule window, oldest word on top
	assign s0    = blk_q[511:480];
	assign s2    = blk_q[447:416];
	assign s8    = blk_q[255:224];
	assign s13   = blk_q[95:64];
	assign sx    = s13 ^ s8 ^ s2 ^ s0;
	assign w_new = {sx[30:0], sx[31]};

	always_comb begin
		case (cmd.stage)
			sha1md_pkg::STG_CH:   f_val = (b_q & c_q) | (~b_q & d_q);
			sha1md_pkg::STG_MAJ:  f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			sha1md_pkg::STG_PAR1: f_val = b_q ^ c_q ^ d_q;
			sha1md_pkg::STG_PAR2: f_val = b_q ^ c_q ^ d_q;
			default:              f_val = b_q ^ c_q ^ d_q;
		endcase
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + s0
		+ sha1md_pkg::round_const(cmd.stage);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= sha1md_pkg::H_INIT;
			fill_q  <= '0;
			total_q <= '0;
		end else begin
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.chain_init) begin
				h_q     <= sha1md_pkg::H_INIT;
				total_q <= '0;
			end else begin
				if (cmd.absorb) begin
					total_q <= total_q + 61'd1;
				end
				if (cmd.chain_add) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (cmd.rnd_step) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.rnd_load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.rnd_step) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_comb begin
		case (cmd.word_sel)
			3'd0:    digest_word = h_q[0];
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			3'd4:    digest_word = h_q[4];
			default: digest_word = h_q[0];
		endcase
	end

	assign word_index = cmd.word_sel;
	assign last_word  = (cmd.word_sel == sha1md_pkg::LAST_WORD);

endmodule
`default_nettype wire

FILE: sv/sha1_message_digest_unit.sv
// SHA-1 digest engine fed one message byte per item. Bytes are taken only while
// the unit is idle; the 64th byte of a block starts the compression, 80 rounds
// at one round per cycle plus a fold of the result into the chaining value, so
// that item holds the input until the fold is done.
// An item with end_of_message set finishes the message: the unit shifts in the
// 0x80 mark, zero fill and the 64-bit bit length one byte per cycle, runs one or
// two compressions, then offers the five digest words H0..H4, one per cycle
// while the sink is ready, with last_word on the fifth. The single round unit and
// the byte-wide block register set these rates; no new item is taken from the end
// item until the fifth word is taken. After the last word the unit is back at the
// initial chaining value, ready for a new message. An item with neither a byte nor
// the end flag is a no-op.
`default_nettype none
module sha1_message_digest_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sha1md_msg_if.sink    msg,
	sha1md_dig_if.source  digest
);

	// commands from the sequencer, fill level back from the datapath
	sha1md_pkg::dp_cmd_t  cmd;
	sha1md_pkg::dp_stat_t stat;

	sha1md_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg.valid),
		.msg_has_byte (msg.has_byte),
		.msg_end      (msg.end_of_message),
		.msg_ready    (msg.ready),
		.dig_valid    (digest.valid),
		.dig_ready    (digest.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	sha1md_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (msg.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest.digest_word),
		.word_index  (digest.word_index),
		.last_word   (digest.last_word)
	);

	// input and output sides never run at the same time
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("input ready while digest words pending");

	// the flagged word is always H4
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.last_word |-> digest.word_index == sha1md_pkg::LAST_WORD)
		else $error("last_word on wrong index");

	// taking the last word returns the unit to accepting bytes
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.ready && digest.last_word |=> msg.ready && !digest.valid)
		else $error("unit did not return to idle after digest");

endmodule
`default_nettype wire
